FILE: hw/rtl/diff_drive_waypoint_to_steps_macros.svh
// Assertion helpers for the checker file.
`ifndef DIFF_DRIVE_WAYPOINT_TO_STEPS_MACROS_SVH
`define DIFF_DRIVE_WAYPOINT_TO_STEPS_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, muted during reset.
`define DDW_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ddw assertion failed");

// Next-cycle implication, sampled on the rising edge, muted during reset.
`define DDW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ddw assertion failed");

`endif

FILE: hw/rtl/ddw_pkg.sv
`default_nettype none
package ddw_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int ANGLE_BITS_DEF = 18;
  localparam int CNT_W          = 22;
  localparam int RATE_W         = 16;
  localparam logic [RATE_W-1:0] RATE_RESET = 16'd500;

  localparam int CORDIC_ITERS = 24;
  localparam int SQRT_STEPS   = 32;

  // 640/(7*pi) in Q24
  localparam logic [28:0] MOVE_K     = 29'd488260911;
  // microsteps per full turn of heading, times two
  localparam logic [17:0] ROT_SCALE  = 18'd256000;
  // ceil(2^20 / 7)
  localparam logic [17:0] DIV7_RECIP = 18'd149797;
  localparam int          DIV7_SHIFT = 20;

  localparam logic MK_ROTATE = 1'b0;
  localparam logic MK_MOVE   = 1'b1;

  typedef struct packed {
    logic             motion_kind;
    logic             direction;
    logic [CNT_W-1:0] step_count;
    logic             last;
  } cmd_t;

  // atan(2^-i) in turns * 2^32
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:    a = 32'h20000000;
      5'd1:    a = 32'h12E4051E;
      5'd2:    a = 32'h09FB385B;
      5'd3:    a = 32'h051111D4;
      5'd4:    a = 32'h028B0D43;
      5'd5:    a = 32'h0145D7E1;
      5'd6:    a = 32'h00A2F61E;
      5'd7:    a = 32'h00517C55;
      5'd8:    a = 32'h0028BE53;
      5'd9:    a = 32'h00145F2F;
      5'd10:   a = 32'h000A2F98;
      5'd11:   a = 32'h000517CC;
      5'd12:   a = 32'h00028BE6;
      5'd13:   a = 32'h000145F3;
      5'd14:   a = 32'h0000A2FA;
      5'd15:   a = 32'h0000517D;
      5'd16:   a = 32'h000028BE;
      5'd17:   a = 32'h0000145F;
      5'd18:   a = 32'h00000A30;
      5'd19:   a = 32'h00000518;
      5'd20:   a = 32'h0000028C;
      5'd21:   a = 32'h00000146;
      5'd22:   a = 32'h000000A3;
      5'd23:   a = 32'h00000051;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/ddw_fifo.sv
`default_nettype none
module ddw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  // store an entry on each accepted transaction
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/ddw_front.sv
`default_nettype none
module ddw_front #(
  parameter int COORD_BITS = ddw_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic                          mq_full,
  input  logic signed [COORD_BITS-1:0]  target_x,
  input  logic signed [COORD_BITS-1:0]  target_y,
  output logic                          mq_push,
  output logic [2*(COORD_BITS+1)-1:0]   mq_data
);
  import ddw_pkg::*;

  localparam int DW = COORD_BITS + 1;

  logic                         have_position;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic signed [DW-1:0]         dx;
  logic signed [DW-1:0]         dy;
  logic                         accept;

  assign accept = push && !mq_full;
  assign dx = {target_x[COORD_BITS-1], target_x} - {pos_x[COORD_BITS-1], pos_x};
  assign dy = {target_y[COORD_BITS-1], target_y} - {pos_y[COORD_BITS-1], pos_y};

  // drop the first waypoint and any waypoint equal to the position
  assign mq_push = accept && have_position && ((dx != '0) || (dy != '0));
  assign mq_data = {dx, dy};

  // hold the last target as the position
  always_ff @(posedge clk) begin
    if (rst) begin
      have_position <= 1'b0;
      pos_x         <= '0;
      pos_y         <= '0;
    end else if (accept) begin
      have_position <= 1'b1;
      pos_x         <= target_x;
      pos_y         <= target_y;
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/ddw_back.sv
`default_nettype none
module ddw_back #(
  parameter int COORD_BITS = ddw_pkg::COORD_BITS_DEF,
  parameter int ANGLE_BITS = ddw_pkg::ANGLE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        mq_empty,
  input  logic [2*(COORD_BITS+1)-1:0] mq_data,
  output logic                        mq_pop,
  input  logic                        oq_full,
  output logic                        oq_push,
  output ddw_pkg::cmd_t               oq_data
);
  import ddw_pkg::*;

  localparam int DW   = COORD_BITS + 1;
  localparam int XW   = COORD_BITS + 33;
  localparam int SQW  = 2 * COORD_BITS + 1;
  localparam int FRAC = 31 - COORD_BITS;
  localparam int MSH  = 55 - COORD_BITS;
  localparam int PW   = ANGLE_BITS + 18;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_PREP = 8'b0000_0010,
    S_SQ   = 8'b0000_0100,
    S_RUN  = 8'b0000_1000,
    S_ANG  = 8'b0001_0000,
    S_DIV  = 8'b0010_0000,
    S_EROT = 8'b0100_0000,
    S_EMOV = 8'b1000_0000
  } state_t;

  state_t                 state;
  state_t                 state_next;
  logic signed [DW-1:0]   dx;
  logic signed [DW-1:0]   dy;
  logic signed [XW-1:0]   cx;
  logic signed [XW-1:0]   cy;
  logic [31:0]            cz;
  logic signed [2*DW-1:0] sqx;
  logic signed [2*DW-1:0] sqy;
  logic [63:0]            v;
  logic [63:0]            r;
  logic [63:0]            bitm;
  logic [4:0]             cnt;
  logic [ANGLE_BITS-1:0]  heading;
  logic [ANGLE_BITS-1:0]  tgt;
  logic                   dir;
  logic [PW-1:0]          prod1;
  logic [60:0]            prodm;
  logic [33:0]            prodq;
  logic [CNT_W-1:0]       mov;

  logic signed [XW-1:0]   x0;
  logic signed [XW-1:0]   y0;
  logic signed [XW-1:0]   xs;
  logic signed [XW-1:0]   ys;
  logic [SQW-1:0]         sqsum;
  logic [63:0]            trial;
  logic [31:0]            zr;
  logic [ANGLE_BITS-1:0]  tgt_c;
  logic [ANGLE_BITS-1:0]  d;
  logic [ANGLE_BITS-1:0]  mag;
  logic                   dir_c;
  logic [PW-1:0]          num;
  logic [15:0]            t;
  logic [61:0]            msum;
  logic [61:0]            shv;
  logic [CNT_W-1:0]       mov_c;
  logic [13:0]            rot;

  // scale deltas into the CORDIC word
  assign x0 = {{(XW-DW-30){dx[DW-1]}}, dx, 30'b0};
  assign y0 = {{(XW-DW-30){dy[DW-1]}}, dy, 30'b0};
  assign xs = cx >>> cnt;
  assign ys = cy >>> cnt;

  assign sqsum = sqx[SQW-1:0] + sqy[SQW-1:0];
  assign trial = r + bitm;

  // round angle, wrap heading change into (-half, +half]
  assign zr    = cz + (32'd1 << (31 - ANGLE_BITS));
  assign tgt_c = zr[31 -: ANGLE_BITS];
  assign d     = tgt_c - heading;
  always_comb begin
    if (d > (ANGLE_BITS'(1) << (ANGLE_BITS - 1))) begin
      mag   = '0 - d;
      dir_c = 1'b0;
    end else begin
      mag   = d;
      dir_c = 1'b1;
    end
  end

  // divide by 14 * 2^A: shift, then reciprocal of seven
  assign num = prod1 + (PW'(7) << ANGLE_BITS);
  assign t   = num[ANGLE_BITS+16:ANGLE_BITS+1];
  assign rot = prodq[DIV7_SHIFT+13:DIV7_SHIFT];

  // round and saturate the move count
  assign msum = {1'b0, prodm} + (62'd1 << (FRAC + 23));
  assign shv  = msum >> MSH;
  assign mov_c = (|shv[61:CNT_W]) ? {CNT_W{1'b1}} : shv[CNT_W-1:0];

  // sequencer
  always_comb begin
    state_next = state;
    mq_pop     = 1'b0;
    oq_push    = 1'b0;
    oq_data    = '0;
    case (state)
      S_IDLE: begin
        if (!mq_empty) begin
          mq_pop     = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: state_next = S_SQ;
      S_SQ:   state_next = S_RUN;
      S_RUN: begin
        if (cnt == 5'(SQRT_STEPS - 1)) begin
          state_next = S_ANG;
        end
      end
      S_ANG: state_next = S_DIV;
      S_DIV: state_next = S_EROT;
      S_EROT: begin
        oq_data.motion_kind = MK_ROTATE;
        oq_data.direction   = dir;
        oq_data.step_count  = CNT_W'(rot);
        oq_data.last        = (mov == '0);
        if (rot == '0) begin
          state_next = S_EMOV;
        end else if (!oq_full) begin
          oq_push    = 1'b1;
          state_next = (mov == '0) ? S_IDLE : S_EMOV;
        end
      end
      S_EMOV: begin
        oq_data.motion_kind = MK_MOVE;
        oq_data.direction   = 1'b1;
        oq_data.step_count  = mov;
        oq_data.last        = 1'b1;
        if (mov == '0) begin
          state_next = S_IDLE;
        end else if (!oq_full) begin
          oq_push    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      heading <= '0;
      cnt     <= '0;
    end else begin
      state <= state_next;
      if (state == S_SQ) begin
        cnt <= '0;
      end else if (state == S_RUN) begin
        cnt <= cnt + 1'b1;
      end
      if (state == S_DIV) begin
        heading <= tgt;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        dx <= mq_data[2*DW-1:DW];
        dy <= mq_data[DW-1:0];
      end
      S_PREP: begin
        sqx <= dx * dx;
        sqy <= dy * dy;
        if (dx < 0) begin
          cx <= -x0;
          cy <= -y0;
          cz <= 32'h80000000;
        end else begin
          cx <= x0;
          cy <= y0;
          cz <= '0;
        end
      end
      S_SQ: begin
        v    <= {1'b0, sqsum, {(2*FRAC){1'b0}}};
        r    <= '0;
        bitm <= 64'h4000_0000_0000_0000;
      end
      S_RUN: begin
        // one root digit per cycle, plus one CORDIC iteration while cnt is below CORDIC_ITERS
        if (cnt < 5'(CORDIC_ITERS)) begin
          if (cy >= 0) begin
            cx <= cx + ys;
            cy <= cy - xs;
            cz <= cz + atan_turn(cnt);
          end else begin
            cx <= cx - ys;
            cy <= cy + xs;
            cz <= cz - atan_turn(cnt);
          end
        end
        if (v >= trial) begin
          v <= v - trial;
          r <= (r >> 1) + bitm;
        end else begin
          r <= r >> 1;
        end
        bitm <= bitm >> 2;
      end
      S_ANG: begin
        tgt   <= tgt_c;
        dir   <= dir_c;
        prod1 <= PW'(mag) * PW'(ROT_SCALE);
        prodm <= 61'(r[31:0]) * 61'(MOVE_K);
      end
      S_DIV: begin
        prodq <= 34'(t) * 34'(DIV7_RECIP);
        mov   <= mov_c;
      end
      default: begin
      end
    endcase
  end
endmodule
`default_nettype wire

FILE: hw/rtl/diff_drive_waypoint_to_steps.sv
// An accepted waypoint passes the front into the waypoint queue, then the back states IDLE, PREP,
// SQ, RUN, ANG, DIV and EROT, which pushes its rotate command if any; EMOV pushes its move command.
// The back sequencer takes one waypoint at a time, its pace set by the 32-step root digit loop that
// runs alongside the 24-iteration CORDIC pass; commands drain 1 per cycle while pop is held and some are queued.
// Waypoints that give no command are dropped at the front and never enter the waypoint queue.
// Reset (rst, synchronous, active high) clears position, heading, queues and sets rate to 500.
`default_nettype none
module diff_drive_waypoint_to_steps #(
  parameter int COORD_BITS = ddw_pkg::COORD_BITS_DEF,
  parameter int ANGLE_BITS = ddw_pkg::ANGLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic signed [COORD_BITS-1:0]      target_x,
  input  logic signed [COORD_BITS-1:0]      target_y,
  output logic                              empty,
  input  logic                              pop,
  output logic                              motion_kind,
  output logic                              direction,
  output logic [ddw_pkg::CNT_W-1:0]         step_count,
  output logic [ddw_pkg::RATE_W-1:0]        rate_hz,
  output logic                              last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ddw_pkg::RATE_W-1:0]        cfg_data
);
  import ddw_pkg::*;

  localparam int MQW = 2 * (COORD_BITS + 1);

  logic             mq_push;
  logic [MQW-1:0]   mq_din;
  logic             mq_full;
  logic             mq_pop;
  logic [MQW-1:0]   mq_dout;
  logic             mq_empty;
  logic             oq_push;
  cmd_t             oq_din;
  logic             oq_full;
  cmd_t             oq_dout;
  logic [RATE_W-1:0] step_rate_hz;

  // hold the step rate register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      step_rate_hz <= RATE_RESET;
    end else if (cfg_valid) begin
      step_rate_hz <= cfg_data;
    end
  end

  assign full = mq_full;

  ddw_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .mq_full  (mq_full),
    .target_x (target_x),
    .target_y (target_y),
    .mq_push  (mq_push),
    .mq_data  (mq_din)
  );

  ddw_fifo #(.WIDTH(MQW), .DEPTH(2)) u_mq (
    .clk   (clk),
    .rst   (rst),
    .push  (mq_push),
    .din   (mq_din),
    .full  (mq_full),
    .pop   (mq_pop),
    .dout  (mq_dout),
    .empty (mq_empty)
  );

  ddw_back #(.COORD_BITS(COORD_BITS), .ANGLE_BITS(ANGLE_BITS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .mq_empty (mq_empty),
    .mq_data  (mq_dout),
    .mq_pop   (mq_pop),
    .oq_full  (oq_full),
    .oq_push  (oq_push),
    .oq_data  (oq_din)
  );

  ddw_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(2)) u_oq (
    .clk   (clk),
    .rst   (rst),
    .push  (oq_push),
    .din   (oq_din),
    .full  (oq_full),
    .pop   (pop),
    .dout  (oq_dout),
    .empty (empty)
  );

  assign motion_kind = oq_dout.motion_kind;
  assign direction   = oq_dout.direction;
  assign step_count  = oq_dout.step_count;
  assign last        = oq_dout.last;
  assign rate_hz     = step_rate_hz;
endmodule
`default_nettype wire

FILE: hw/rtl/ddw_checker.sv
`default_nettype none
`include "diff_drive_waypoint_to_steps_macros.svh"
module ddw_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      empty,
  input logic                      pop,
  input logic                      motion_kind,
  input logic                      direction,
  input logic [ddw_pkg::CNT_W-1:0] step_count,
  input logic                      last
);
  // a waiting command holds until taken
  `DDW_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(step_count) && $stable(last))
  // a move always closes its waypoint and drives forward
  `DDW_ASSERT_NOW(a_move_last, !empty && motion_kind, last && direction)
  // zero counts are never shown
  `DDW_ASSERT_NOW(a_nonzero, !empty, step_count != '0)
  // a rotate that is not last must be followed by its move
  `DDW_ASSERT_NEXT(a_rot_then_move, !empty && pop && !motion_kind && !last,
                   empty || motion_kind)
endmodule

bind diff_drive_waypoint_to_steps ddw_checker u_ddw_checker (
  .clk         (clk),
  .rst         (rst),
  .empty       (empty),
  .pop         (pop),
  .motion_kind (motion_kind),
  .direction   (direction),
  .step_count  (step_count),
  .last        (last)
);
`default_nettype wire

FILE: bench/diff_drive_waypoint_to_steps_tb.sv
`default_nettype none
module diff_drive_waypoint_to_steps_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ddw_pkg::*;

  localparam int AB = ANGLE_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct {
    logic             kind;
    logic             dir;
    logic [CNT_W-1:0] count;
    logic [RATE_W-1:0] rate;
    logic             last;
  } motor_cmd_t;

  // Expected motor commands, worked out from each accepted waypoint
  class motion_scoreboard;
    motor_cmd_t        cmd_q[$];
    logic [RATE_W-1:0] rate;
    bit                have_pos;
    logic signed [15:0] px, py;
    logic [AB-1:0]     heading;
    int                errors;
    int                waypoints;
    int                commands;
    bit [31:0]         atan_lut[CORDIC_ITERS];

    function new();
      atan_lut = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
                   32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                   32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
                   32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
                   32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
                   32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
      rate = RATE_RESET;
      have_pos = 0;
      px = 0;
      py = 0;
      heading = '0;
      errors = 0;
      waypoints = 0;
      commands = 0;
    endfunction

    // Vectoring CORDIC: bearing of the delta as a binary angle
    function logic [AB-1:0] bearing(longint dx, longint dy);
      longint xa, ya, xs, ys;
      bit [31:0] z;
      xa = dx * (64'sd1 <<< 30);
      ya = dy * (64'sd1 <<< 30);
      z = 0;
      if (xa < 0) begin
        xa = -xa;
        ya = -ya;
        z = 32'h80000000;
      end
      for (int i = 0; i < CORDIC_ITERS; i++) begin
        xs = xa >>> i;
        ys = ya >>> i;
        if (ya >= 0) begin
          xa = xa + ys;
          ya = ya - xs;
          z = z + atan_lut[i];
        end else begin
          xa = xa - ys;
          ya = ya + xs;
          z = z - atan_lut[i];
        end
      end
      z = z + (32'd1 << (31 - AB));
      return z[31 -: AB];
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function void push_cmd(logic kind, logic dir, longint unsigned cnt);
      motor_cmd_t c;
      c.kind = kind;
      c.dir = dir;
      c.count = (cnt > 64'h3FFFFF) ? {CNT_W{1'b1}} : cnt[CNT_W-1:0];
      c.rate = rate;
      c.last = 0;
      cmd_q.push_back(c);
    endfunction

    // Note an accepted waypoint and queue the commands it causes
    function void note_waypoint(logic signed [15:0] tx, logic signed [15:0] ty);
      longint dx, dy;
      logic [AB-1:0] tgt, d, mag;
      logic dir;
      longint unsigned rot, sq, q, mov;
      int n;
      waypoints++;
      if (!have_pos) begin
        px = tx;
        py = ty;
        heading = '0;
        have_pos = 1;
        return;
      end
      dx = longint'(tx) - longint'(px);
      dy = longint'(ty) - longint'(py);
      if (dx == 0 && dy == 0) return;
      n = cmd_q.size();
      tgt = bearing(dx, dy);
      d = tgt - heading;
      if (d > (1 << (AB - 1))) begin
        mag = -d;
        dir = 0;
      end else begin
        mag = d;
        dir = 1;
      end
      rot = (longint'(mag) * 256000 + (64'd7 << AB)) / (64'd14 << AB);
      if (rot > 0) push_cmd(MK_ROTATE, dir, rot);
      sq = longint'(dx * dx) + longint'(dy * dy);
      q = int_sqrt(sq << 30);
      mov = (q * 64'd488260911 + (64'd1 << 38)) >> 39;
      if (mov > 0) push_cmd(MK_MOVE, 1'b1, mov);
      if (cmd_q.size() > n) cmd_q[$].last = 1;
      px = tx;
      py = ty;
      heading = tgt;
    endfunction

    // Compare one popped command with the oldest expectation
    function void check_cmd(logic kind, logic dir, logic [CNT_W-1:0] cnt,
                            logic [RATE_W-1:0] r, logic lst);
      motor_cmd_t e;
      commands++;
      if (cmd_q.size() == 0) begin
        $display("%0t: unexpected command kind=%0d dir=%0d count=%0d rate=%0d last=%0d",
                 $time, kind, dir, cnt, r, lst);
        errors++;
        return;
      end
      e = cmd_q.pop_front();
      if (kind !== e.kind) begin
        $display("%0t: motion_kind expected %0d actual %0d", $time, e.kind, kind);
        errors++;
      end
      if (dir !== e.dir) begin
        $display("%0t: direction expected %0d actual %0d", $time, e.dir, dir);
        errors++;
      end
      if (cnt !== e.count) begin
        $display("%0t: step_count expected %0d actual %0d", $time, e.count, cnt);
        errors++;
      end
      if (r !== e.rate) begin
        $display("%0t: rate_hz expected %0d actual %0d", $time, e.rate, r);
        errors++;
      end
      if (lst !== e.last) begin
        $display("%0t: last expected %0d actual %0d", $time, e.last, lst);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst, push, full, empty, pop;
  logic signed [15:0] target_x, target_y;
  logic motion_kind, direction, last;
  logic [CNT_W-1:0] step_count;
  logic [RATE_W-1:0] rate_hz;
  logic cfg_valid, cfg_ready;
  logic [RATE_W-1:0] cfg_data;

  motion_scoreboard sb;
  int send_idle_pct, recv_stall_pct;
  bit hold_req;
  int hold_left;
  int idle_cycles;
  int rate_writes;
  logic signed [15:0] prev_x, prev_y;

  diff_drive_waypoint_to_steps DUT (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .target_x(target_x), .target_y(target_y),
    .empty(empty), .pop(pop),
    .motion_kind(motion_kind), .direction(direction), .step_count(step_count),
    .rate_hz(rate_hz), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  initial begin
    clk = 0;
    rst = 1;
    push = 0;
    pop = 0;
    target_x = 0;
    target_y = 0;
    cfg_valid = 0;
    cfg_data = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 0;
    hold_left = 0;
    idle_cycles = 0;
    rate_writes = 0;
    prev_x = 0;
    prev_y = 0;
    sb = new();
  end

  // Offer one waypoint and hold it until the block takes it
  task automatic send_waypoint(logic signed [15:0] x, logic signed [15:0] y);
    int gap;
    push <= 1;
    target_x <= x;
    target_y <= y;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_waypoint(x, y);
    prev_x = x;
    prev_y = y;
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 0;
      gap = 1;
      while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Write the step rate once the block has drained
  task automatic write_rate(logic [RATE_W-1:0] v);
    push <= 0;
    @(posedge clk);
    while (sb.cmd_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    sb.rate = v;
    rate_writes++;
  endtask

  task automatic random_waypoint();
    int pick;
    logic signed [15:0] x, y;
    pick = $urandom_range(99);
    if (pick < 40) begin
      x = 16'($urandom);
      y = 16'($urandom);
    end else if (pick < 75) begin
      // short hop near the current position
      x = prev_x + $signed(16'($urandom_range(64))) - 16'sd32;
      y = prev_y + $signed(16'($urandom_range(64))) - 16'sd32;
    end else if (pick < 85) begin
      // axis-aligned or diagonal hop for exact bearings
      x = prev_x;
      y = prev_y;
      case ($urandom_range(3))
        0: x = prev_x + 16'($urandom_range(500));
        1: x = prev_x - 16'($urandom_range(500));
        2: y = prev_y + 16'($urandom_range(500));
        default: begin
          x = prev_x + 16'sd100;
          y = prev_y - 16'sd100;
        end
      endcase
    end else if (pick < 93) begin
      // repeat of the current position
      x = prev_x;
      y = prev_y;
    end else begin
      x = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      y = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
    end
    send_waypoint(x, y);
  endtask

  // Receiver: check each popped command, stall at random or hold off
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (pop && !empty) sb.check_cmd(motion_kind, direction, step_count, rate_hz, last);
      if (hold_left > 0) begin
        hold_left--;
        pop <= 0;
      end else if (hold_req) begin
        hold_req = 0;
        hold_left = 600;
        pop <= 0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("diff_drive_waypoint_to_steps regression: fail");
      $finish;
    end
  end

  initial begin
    int idle_tab[4];
    int stall_tab[4];
    idle_tab = '{0, 78, 0, 29};
    stall_tab = '{0, 0, 78, 29};
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: first fix, repeat, straight ahead, half turn, extremes, rate writes
    send_waypoint(16'sd0, 16'sd0);
    send_waypoint(16'sd0, 16'sd0);
    send_waypoint(16'sd100, 16'sd0);
    send_waypoint(16'sd0, 16'sd0);
    send_waypoint(16'sd1, 16'sd0);
    send_waypoint(16'sd1, 16'sd1);
    send_waypoint(16'sd0, 16'sd1);
    send_waypoint(16'sd0, -16'sd1);
    send_waypoint(16'sh7FFF, 16'sh7FFF);
    send_waypoint(16'sh8000, 16'sh8000);
    send_waypoint(16'sh7FFF, 16'sh8000);
    send_waypoint(16'sh8000, 16'sh7FFF);
    send_waypoint(16'sh8000, 16'sh8000);
    send_waypoint(16'sh7FFF, 16'sh8000);
    write_rate(16'd0);
    send_waypoint(16'sd10, 16'sd10);
    send_waypoint(-16'sd10, 16'sd10);
    write_rate(16'hFFFF);
    send_waypoint(-16'sd10, -16'sd10);
    send_waypoint(16'sd10, -16'sd10);
    write_rate(16'd1);
    send_waypoint(16'sd10, 16'sd10);
    send_waypoint(16'sd10, 16'sd10);

    // Long hold-off on the result side while waypoints keep coming
    hold_req = 1;
    repeat (40) random_waypoint();

    for (int p = 0; p < 4; p++) begin
      write_rate(p == 0 ? RATE_RESET : 16'($urandom_range(65535)));
      send_idle_pct = idle_tab[p];
      recv_stall_pct = stall_tab[p];
      repeat (420) random_waypoint();
    end
    push <= 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;

    @(posedge clk);
    while (sb.cmd_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d waypoints, %0d motor commands, %0d rate writes,",
             sb.waypoints, sb.commands, rate_writes);
    $display("with idle and stall phases and a long result-side hold-off.");
    if (sb.errors == 0 && sb.cmd_q.size() == 0)
      $display("diff_drive_waypoint_to_steps regression: pass");
    else
      $display("diff_drive_waypoint_to_steps regression: fail");
    $finish;
  end
endmodule
`default_nettype wire
